/* design/rtcm3_pkg.sv */
// ----------------------------------------------------------------------------
// rtcm3_pkg
// Shared types, constants and the byte-wide CRC-24Q step for the RTCM3 parser.
// ----------------------------------------------------------------------------
package rtcm3_pkg;

  localparam logic [7:0]  PreambleByte = 8'hD3;
  localparam logic [7:0]  SyncRsvdMask = 8'hFC;
  localparam logic [7:0]  SyncLenMask  = 8'h03;
  localparam logic [24:0] Crc24qPoly   = 25'h1864CFB;

  typedef enum logic [1:0] {
    STATUS_INCOMPLETE = 2'd0,
    STATUS_OK         = 2'd1,
    STATUS_BAD_CRC    = 2'd2
  } frame_status_e;

  typedef struct packed {
    frame_status_e frame_status;
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic [9:0]    payload_index;
    logic [9:0]    payload_length;
  } rtcm3_result_t;

  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ Crc24qPoly;
      end
    end
    return c[23:0];
  endfunction

endpackage

/* design/rtcm3_parse.sv */
// ----------------------------------------------------------------------------
// rtcm3_parse
// Frame state machine: preamble hunt, length capture, payload indexing,
// CRC-24Q accumulation and check byte compare. One byte per accepted transaction.
// ----------------------------------------------------------------------------
module rtcm3_parse
  import rtcm3_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output rtcm3_result_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREAMBLE = 3'd1,
    PH_SYNC     = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECK1   = 3'd4,
    PH_CHECK2   = 3'd5,
    PH_CHECK3   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] crc_q, crc_d;
  logic [9:0]  len_q, len_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [1:0]  hi_len_q, hi_len_d;
  logic [7:0]  chk1_q, chk1_d;
  logic [7:0]  chk2_q, chk2_d;

  logic [23:0] crc_step;
  logic [9:0]  cnt_inc;
  logic [9:0]  new_len;

  assign crc_step = crc24q_byte((phase_q == PH_PREAMBLE || phase_q == PH_SYNC ||
                                 phase_q == PH_PAYLOAD) ? crc_q : 24'h000000, rx_byte_i);
  assign cnt_inc  = cnt_q + 10'd1;
  assign new_len  = {hi_len_q, rx_byte_i};

  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    hi_len_d = hi_len_q;
    chk1_d   = chk1_q;
    chk2_d   = chk2_q;
    res_o    = '{frame_status: STATUS_INCOMPLETE, payload_valid: 1'b0,
                 payload_byte: 8'h00, payload_index: 10'd0, payload_length: 10'd0};
    case (phase_q)
      PH_PREAMBLE: begin
        if ((rx_byte_i & SyncRsvdMask) == 8'h00) begin
          hi_len_d = rx_byte_i[1:0] & SyncLenMask[1:0];
          crc_d    = crc_step;
          phase_d  = PH_SYNC;
        end else begin
          phase_d  = PH_IDLE;
        end
      end
      PH_SYNC: begin
        len_d   = new_len;
        cnt_d   = 10'd0;
        crc_d   = crc_step;
        phase_d = (new_len == 10'd0) ? PH_CHECK1 : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = cnt_q;
        crc_d = crc_step;
        cnt_d = cnt_inc;
        if (cnt_inc == len_q) begin
          phase_d = PH_CHECK1;
        end
      end
      PH_CHECK1: begin
        chk1_d  = rx_byte_i;
        phase_d = PH_CHECK2;
      end
      PH_CHECK2: begin
        chk2_d  = rx_byte_i;
        phase_d = PH_CHECK3;
      end
      PH_CHECK3: begin
        res_o.frame_status = ({chk1_q, chk2_q, rx_byte_i} == crc_q) ? STATUS_OK
                                                                     : STATUS_BAD_CRC;
        phase_d = PH_IDLE;
      end
      default: begin
        if (rx_byte_i == PreambleByte) begin
          len_d   = 10'd0;
          crc_d   = crc_step;
          phase_d = PH_PREAMBLE;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
    res_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      crc_q    <= 24'h000000;
      len_q    <= 10'd0;
      cnt_q    <= 10'd0;
      hi_len_q <= 2'd0;
      chk1_q   <= 8'h00;
      chk2_q   <= 8'h00;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      hi_len_q <= hi_len_d;
      chk1_q   <= chk1_d;
      chk2_q   <= chk2_d;
    end
  end

endmodule

/* design/rtcm3_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// rtcm3_frame_parser_unit
// RTCM3 frame parser: one result per received byte, CRC-24Q checked.
// An accepted byte's result is registered into the output or, when stalled, the skid.
// One byte per cycle while in_stall_o is low; parse and CRC steps are combinational.
// A skid register lets a new byte in while the current result is stalled.
// Reset: asynchronous active low; parser returns to preamble hunt, CRC and counts zero.
// ----------------------------------------------------------------------------
module rtcm3_frame_parser_unit
  import rtcm3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] frame_status_o,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [9:0] payload_index_o,
  output logic [9:0] payload_length_o
);

  rtcm3_result_t res;
  rtcm3_result_t out_q, skid_q;
  logic          out_vld_q, skid_vld_q;
  logic          accept, pop;

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_vld_q && !out_stall_i;

  rtcm3_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_vld_q || pop) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_vld_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign frame_status_o   = out_q.frame_status;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_index_o  = out_q.payload_index;
  assign payload_length_o = out_q.payload_length;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without an output entry");

  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.payload_valid) |-> (out_q.frame_status == STATUS_INCOMPLETE))
    else $error("payload byte reported together with a frame status");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.payload_valid) |-> (out_q.payload_index < out_q.payload_length))
    else $error("payload index beyond frame length");

  a_stalled_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

/* tb/tb_rtcm3_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_rtcm3_frame_parser_unit
// Self-checking bench for the RTCM3 frame parser. A directed table covers
// reset values, bad length bytes, an empty frame, an in-frame preamble and a
// bad check; random framed traffic, noise and broken headers follow. Each
// result is compared against a CRC-24Q framing predictor, or a pinned table row.
// ----------------------------------------------------------------------------
module tb_rtcm3_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcm3_pkg::*;

  localparam int unsigned RandomBytes = 750;
  localparam int unsigned DeadLimit   = 2000;
  localparam int unsigned TailCycles  = 10;

  typedef enum logic [1:0] {ROW_BYTE, ROW_SOF, ROW_CRC, ROW_CRC_BAD} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [7:0]    value;
    logic          pinned;
    rtcm3_result_t want;
  } dir_row_t;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_MID, PH_CRC_LO
  } phase_e;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] frame_status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [9:0] payload_index;
  logic [9:0] payload_length;

  // typed expectation that travels with the byte on the input side
  logic          pin_on   = 1'b0;
  rtcm3_result_t pin_want = '0;

  logic steady = 1'b0;

  rtcm3_result_t frame_results_q[$];
  int unsigned   err_count    = 0;
  int unsigned   sent_count   = 0;
  int unsigned   ok_frames    = 0;
  int unsigned   bad_frames   = 0;
  int unsigned   payload_seen = 0;
  int unsigned   dead_cycles  = 0;

  // predictor state
  phase_e      p_phase = PH_HUNT;
  logic [23:0] p_crc   = '0;
  logic [9:0]  p_len   = '0;
  logic [9:0]  p_count = '0;
  logic [1:0]  p_hi    = '0;
  logic [7:0]  p_chk1  = '0;
  logic [7:0]  p_chk2  = '0;

  rtcm3_frame_parser_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_status_o  (frame_status),
    .payload_valid_o (payload_valid),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .payload_length_o(payload_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] r;
    int          k;
    r = crc ^ {b, 16'h0000};
    for (k = 0; k < 8; k++) begin
      r = r[23] ? ({r[22:0], 1'b0} ^ Crc24qPoly[23:0]) : {r[22:0], 1'b0};
    end
    return r;
  endfunction

  function automatic rtcm3_result_t parse_rx_byte(input logic [7:0] c);
    rtcm3_result_t r;
    r = '0;
    case (p_phase)
      PH_LEN_HI: begin
        if ((c & SyncRsvdMask) == 8'h00) begin
          p_hi    = c[1:0];
          p_crc   = crc24q_next(p_crc, c);
          p_phase = PH_LEN_LO;
        end else begin
          p_phase = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        p_len   = {p_hi, c};
        p_count = '0;
        p_crc   = crc24q_next(p_crc, c);
        p_phase = (p_len == 10'd0) ? PH_CRC_HI : PH_DATA;
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = c;
        r.payload_index = p_count;
        p_crc           = crc24q_next(p_crc, c);
        p_count         = p_count + 10'd1;
        if (p_count == p_len) begin
          p_phase = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        p_chk1  = c;
        p_phase = PH_CRC_MID;
      end
      PH_CRC_MID: begin
        p_chk2  = c;
        p_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r.frame_status = ({p_chk1, p_chk2, c} == p_crc) ? STATUS_OK : STATUS_BAD_CRC;
        p_phase        = PH_HUNT;
      end
      default: begin
        if (c == PreambleByte) begin
          p_len   = '0;
          p_crc   = crc24q_next(24'h0, c);
          p_phase = PH_LEN_HI;
        end else begin
          p_phase = PH_HUNT;
        end
      end
    endcase
    r.payload_length = p_len;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // scoreboard: results are checked first, then the accepted byte is predicted
  always @(posedge clk) begin : scoreboard
    rtcm3_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction, expected none, actual status %0h length %0h",
                   $time, frame_status, payload_length);
        end else begin
          want = frame_results_q.pop_front();
          check_field("frame_status", int'(want.frame_status), frame_status);
          check_field("payload_valid", want.payload_valid, payload_valid);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("payload_index", want.payload_index, payload_index);
          check_field("payload_length", want.payload_length, payload_length);
          if (want.frame_status == STATUS_OK) ok_frames++;
          if (want.frame_status == STATUS_BAD_CRC) bad_frames++;
          if (want.payload_valid) payload_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        want = parse_rx_byte(rx_byte);
        if (pin_on) begin
          want = pin_want;
        end
        frame_results_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        dead_cycles <= 0;
      end else begin
        dead_cycles <= dead_cycles + 1;
      end
      if (dead_cycles >= DeadLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, dead_cycles);
        $display("tb_rtcm3_frame_parser_unit NOT OK");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99, 0) < 33);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic pinned, input rtcm3_result_t want);
    while (!steady && ($urandom_range(99, 0) < 33)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    pin_on   <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // sends the first keep bytes of a frame; a spoiled frame has one check bit flipped
  task automatic send_frame(input logic [9:0] len, input logic spoil, input int unsigned keep);
    logic [7:0]  frame_q[$];
    logic [23:0] crc;
    frame_q.push_back(PreambleByte);
    frame_q.push_back({6'b000000, len[9:8]});
    frame_q.push_back(len[7:0]);
    repeat (len) begin
      frame_q.push_back(($urandom_range(15, 0) == 0) ? PreambleByte : 8'($urandom_range(255, 0)));
    end
    crc = 24'h0;
    foreach (frame_q[i]) crc = crc24q_next(crc, frame_q[i]);
    if (spoil) begin
      crc = crc ^ (24'h1 << $urandom_range(23, 0));
    end
    frame_q.push_back(crc[23:16]);
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    foreach (frame_q[i]) begin
      if (i < keep) send_byte(frame_q[i], 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  dir_row_t dir_rows[22] = '{
    '{ROW_BYTE,    8'h00, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'hFF, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_SOF,     8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'hFC, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_SOF,     8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'h00, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_SOF,     8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'h00, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'h00, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_CRC,     8'd0,  1'b0, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_CRC,     8'd1,  1'b0, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_CRC,     8'd2,  1'b1, '{STATUS_OK,         1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_SOF,     8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'h00, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_BYTE,    8'h02, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd2}},
    '{ROW_BYTE,    8'hD3, 1'b1, '{STATUS_INCOMPLETE, 1'b1, 8'hD3, 10'd0, 10'd2}},
    '{ROW_BYTE,    8'hFF, 1'b1, '{STATUS_INCOMPLETE, 1'b1, 8'hFF, 10'd1, 10'd2}},
    '{ROW_CRC,     8'd0,  1'b0, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_CRC,     8'd1,  1'b0, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd0}},
    '{ROW_CRC_BAD, 8'd2,  1'b1, '{STATUS_BAD_CRC,    1'b0, 8'h00, 10'd0, 10'd2}},
    '{ROW_BYTE,    8'hFF, 1'b1, '{STATUS_INCOMPLETE, 1'b0, 8'h00, 10'd0, 10'd2}}
  };

  initial begin
    dir_row_t    row;
    logic [7:0]  b;
    logic [23:0] tx_crc;
    logic [9:0]  len;
    int unsigned rand_base;
    int unsigned pick;
    int unsigned done_count;
    logic        big_sent;

    tx_crc   = '0;
    big_sent = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_SOF: begin
          tx_crc = crc24q_next(24'h0, row.value);
          b      = row.value;
        end
        ROW_BYTE: begin
          tx_crc = crc24q_next(tx_crc, row.value);
          b      = row.value;
        end
        default: begin
          b = 8'(tx_crc >> (8 * (2 - int'(row.value))));
          if (row.kind == ROW_CRC_BAD) b = b ^ 8'h01;
        end
      endcase
      send_byte(b, row.pinned, row.want);
    end
    drain_results();

    rand_base = sent_count;
    done_count = 0;
    while (done_count < RandomBytes) begin
      steady = (done_count >= 300) && (done_count < 420);
      if (!big_sent && (done_count >= 450)) begin
        send_frame(10'h100, 1'b0, 2000);
        big_sent = 1'b1;
        drain_results();
      end
      pick = $urandom_range(99, 0);
      len  = 10'd0;
      if (pick < 70) begin
        pick = $urandom_range(99, 0);
        if (pick < 15) len = 10'd0;
        else if (pick < 95) len = 10'($urandom_range(16, 1));
        else len = 10'($urandom_range(300, 17));
        send_frame(len, $urandom_range(4, 0) == 0, 2000);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)), 1'b0, '0);
      end else if (pick < 90) begin
        send_byte(PreambleByte, 1'b0, '0);
        send_byte({6'($urandom_range(63, 1)), 2'($urandom_range(3, 0))}, 1'b0, '0);
      end else begin
        len = 10'($urandom_range(8, 2));
        send_frame(len, 1'b0, $urandom_range(int'(len) + 2, 1));
      end
      done_count = sent_count - rand_base;
    end
    steady = 1'b0;

    drain_results();
    repeat (TailCycles) @(posedge clk);
    $display("sent %0d bytes: %0d frames with matching check, %0d with bad check,",
             sent_count, ok_frames, bad_frames);
    $display("%0d payload bytes, plus noise, broken headers and cut-off frames", payload_seen);
    if (err_count == 0) begin
      $display("tb_rtcm3_frame_parser_unit OK");
    end else begin
      $display("tb_rtcm3_frame_parser_unit NOT OK");
    end
    $finish;
  end

endmodule
